### design/qslerp_pkg.sv
// Shared types, constants and the arctangent table for the quaternion slerp block.
package qslerp_pkg;

    localparam int ROOT_W = 31;   // square root of a Q.60 radicand
    localparam int RAD_W  = 61;   // radicand 1 - d*d in Q.60
    localparam int REM_W  = 62;   // root remainder incl. trial growth
    localparam int ANG_W  = 34;   // CORDIC datapath, Q.30 with headroom
    localparam int QUOT_W = 33;   // ratio magnitude up to 4.0 in Q.30, plus overflow room
    localparam int DREM_W = 64;   // divider remainder
    localparam int ATAN_N = 24;

    localparam logic [14:0] THRESH_RST = 15'd16376;
    localparam logic [32:0] DOT_ONE    = 33'h0_1000_0000;             // 1.0 in Q4.28
    localparam logic [60:0] RAD_ONE    = 61'h1000_0000_0000_0000;     // 1.0 in Q.60
    localparam logic [32:0] QMAX       = 33'h1_0000_0000;             // 4.0 in Q.30
    localparam logic signed [49:0]      HALF_PI_P = 50'sh0_6487_ED51;
    localparam logic signed [ANG_W-1:0] KINV30    = 34'sh0_26DD_3B6A;

    typedef struct packed {
        logic [3:0][15:0] a;      // start quaternion, w x y z at 0..3
        logic [3:0][16:0] e;      // end quaternion after the short-arc sign flip
        logic [14:0]      frac;
        logic             lerp;
        logic [30:0]      d30;    // clamped dot, Q.30
        logic [30:0]      s30;    // sin(theta0), Q.30
    } t_side;

    localparam int SIDE_W = $bits(t_side);

    typedef struct packed {
        t_side side;
        logic  swap;
    } t_rside;

    typedef struct packed {
        t_side                  side;
        logic [ANG_W-1:0]       ct;
        logic                   neg;
    } t_dside;

    typedef struct packed {
        logic [3:0][15:0] r;
        logic             lerp;
    } t_res;

    function automatic logic [ANG_W-1:0] atan_val(input int unsigned idx);
        logic [ANG_W-1:0] v;
        case (idx)
            0:       v = 34'h0_3243_F6A8;
            1:       v = 34'h0_1DAC_6705;
            2:       v = 34'h0_0FAD_BAFC;
            3:       v = 34'h0_07F5_6EA6;
            4:       v = 34'h0_03FE_AB76;
            5:       v = 34'h0_01FF_D55B;
            6:       v = 34'h0_00FF_FAAA;
            7:       v = 34'h0_007F_FF55;
            8:       v = 34'h0_003F_FFEA;
            9:       v = 34'h0_001F_FFFD;
            10:      v = 34'h0_000F_FFFF;
            11:      v = 34'h0_0007_FFFF;
            12:      v = 34'h0_0003_FFFF;
            13:      v = 34'h0_0001_FFFF;
            14:      v = 34'h0_0000_FFFF;
            15:      v = 34'h0_0000_7FFF;
            16:      v = 34'h0_0000_3FFF;
            17:      v = 34'h0_0000_1FFF;
            18:      v = 34'h0_0000_0FFF;
            19:      v = 34'h0_0000_07FF;
            20:      v = 34'h0_0000_03FF;
            21:      v = 34'h0_0000_01FF;
            22:      v = 34'h0_0000_00FF;
            23:      v = 34'h0_0000_007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [53:0] v);
        logic [15:0] o;
        if (v > 54'sd32767) begin
            o = 16'h7FFF;
        end else if (v < -54'sd32768) begin
            o = 16'h8000;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

endpackage

### design/qslerp_if.sv
// Valid/ready channel interfaces for the slerp input and result beats.
interface qslerp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic [14:0]        frac;

    modport source(output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, frac, input ready);
    modport sink(input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, frac, output ready);
endinterface

interface qslerp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r_w;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic               used_lerp;

    modport source(output valid, r_w, r_x, r_y, r_z, used_lerp, input ready);
    modport sink(input valid, r_w, r_x, r_y, r_z, used_lerp, output ready);
endinterface

### design/qslerp_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module qslerp_sqrt import qslerp_pkg::*; #(
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SB_W-1:0]   i_side,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_valid,
    output logic [SB_W-1:0]   o_side,
    output logic [ROOT_W-1:0] o_root
);

    logic [REM_W-1:0]  w_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] w_root [ROOT_W+1];
    logic              w_vld  [ROOT_W+1];
    logic [SB_W-1:0]   w_side [ROOT_W+1];

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic              r_vld  [ROOT_W];
    logic [SB_W-1:0]   r_side [ROOT_W];

    assign w_rem[0]  = {1'b0, i_rad};
    assign w_root[0] = '0;
    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        logic [REM_W-1:0] w_trial;
        logic             w_take;

        // (root + 2^K)^2 - root^2
        assign w_trial = ({{(REM_W-ROOT_W){1'b0}}, w_root[j]} << (K + 1))
                       + (REM_W'(1) << (2 * K));
        assign w_take  = w_rem[j] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= w_take ? w_rem[j] - w_trial : w_rem[j];
                r_root[j] <= w_take ? (w_root[j] | (ROOT_W'(1) << K)) : w_root[j];
                r_side[j] <= w_side[j];
            end
        end

        assign w_rem[j+1]  = r_rem[j];
        assign w_root[j+1] = r_root[j];
        assign w_vld[j+1]  = r_vld[j];
        assign w_side[j+1] = r_side[j];
    end

    assign o_valid = w_vld[ROOT_W];
    assign o_side  = w_side[ROOT_W];
    assign o_root  = w_root[ROOT_W];

endmodule

### design/qslerp_cordic.sv
// Pipelined CORDIC, vectoring or rotation mode, one iteration per stage.
module qslerp_cordic import qslerp_pkg::*; #(
    parameter int NSTAGE = 16,
    parameter bit VECTOR = 1'b1,
    parameter int SB_W   = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [SB_W-1:0]         i_side,
    input  logic signed [ANG_W-1:0] i_x,
    input  logic signed [ANG_W-1:0] i_y,
    input  logic signed [ANG_W-1:0] i_z,
    output logic                    o_valid,
    output logic [SB_W-1:0]         o_side,
    output logic signed [ANG_W-1:0] o_x,
    output logic signed [ANG_W-1:0] o_y,
    output logic signed [ANG_W-1:0] o_z
);

    logic signed [ANG_W-1:0] w_x [NSTAGE+1];
    logic signed [ANG_W-1:0] w_y [NSTAGE+1];
    logic signed [ANG_W-1:0] w_z [NSTAGE+1];
    logic                    w_vld  [NSTAGE+1];
    logic [SB_W-1:0]         w_side [NSTAGE+1];

    logic signed [ANG_W-1:0] r_x [NSTAGE];
    logic signed [ANG_W-1:0] r_y [NSTAGE];
    logic signed [ANG_W-1:0] r_z [NSTAGE];
    logic                    r_vld  [NSTAGE];
    logic [SB_W-1:0]         r_side [NSTAGE];

    assign w_x[0]    = i_x;
    assign w_y[0]    = i_y;
    assign w_z[0]    = i_z;
    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;

    for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
        localparam logic signed [ANG_W-1:0] ATAN = atan_val(i);
        logic signed [ANG_W-1:0] w_xs;
        logic signed [ANG_W-1:0] w_ys;
        logic                    w_up;

        assign w_xs = w_x[i] >>> i;
        assign w_ys = w_y[i] >>> i;
        // vectoring drives y toward zero, rotation drives z toward zero
        assign w_up = VECTOR ? !w_y[i][ANG_W-1] : w_z[i][ANG_W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= w_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_up) begin
                    r_x[i] <= w_x[i] + w_ys;
                    r_y[i] <= w_y[i] - w_xs;
                    r_z[i] <= w_z[i] + ATAN;
                end else begin
                    r_x[i] <= w_x[i] - w_ys;
                    r_y[i] <= w_y[i] + w_xs;
                    r_z[i] <= w_z[i] - ATAN;
                end
                r_side[i] <= w_side[i];
            end
        end

        assign w_x[i+1]    = r_x[i];
        assign w_y[i+1]    = r_y[i];
        assign w_z[i+1]    = r_z[i];
        assign w_vld[i+1]  = r_vld[i];
        assign w_side[i+1] = r_side[i];
    end

    assign o_valid = w_vld[NSTAGE];
    assign o_side  = w_side[NSTAGE];
    assign o_x     = w_x[NSTAGE];
    assign o_y     = w_y[NSTAGE];
    assign o_z     = w_z[NSTAGE];

endmodule

### design/qslerp_div.sv
// Pipelined restoring divider for (num * 2^30) / den, one quotient bit per stage.
module qslerp_div import qslerp_pkg::*; #(
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SB_W-1:0]   i_side,
    input  logic [QUOT_W-1:0] i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic              o_valid,
    output logic [SB_W-1:0]   o_side,
    output logic [QUOT_W-1:0] o_quot,
    output logic              o_ovf
);

    logic [DREM_W-1:0] w_rem  [QUOT_W+1];
    logic [QUOT_W-1:0] w_quot [QUOT_W+1];
    logic [ROOT_W-1:0] w_den  [QUOT_W+1];
    logic              w_ovf  [QUOT_W+1];
    logic              w_vld  [QUOT_W+1];
    logic [SB_W-1:0]   w_side [QUOT_W+1];

    logic [DREM_W-1:0] r_rem  [QUOT_W];
    logic [QUOT_W-1:0] r_quot [QUOT_W];
    logic [ROOT_W-1:0] r_den  [QUOT_W];
    logic              r_ovf  [QUOT_W];
    logic              r_vld  [QUOT_W];
    logic [SB_W-1:0]   r_side [QUOT_W];

    assign w_rem[0]  = {1'b0, i_num, 30'b0};
    assign w_quot[0] = '0;
    assign w_den[0]  = i_den;
    // quotient would need more than QUOT_W bits
    assign w_ovf[0]  = {1'b0, i_num} >= {i_den, 3'b000};
    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        localparam int K = QUOT_W - 1 - j;
        logic [DREM_W-1:0] w_trial;
        logic              w_take;

        assign w_trial = {{(DREM_W-ROOT_W){1'b0}}, w_den[j]} << K;
        assign w_take  = w_rem[j] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= w_take ? w_rem[j] - w_trial : w_rem[j];
                r_quot[j] <= w_take ? (w_quot[j] | (QUOT_W'(1) << K)) : w_quot[j];
                r_den[j]  <= w_den[j];
                r_ovf[j]  <= w_ovf[j];
                r_side[j] <= w_side[j];
            end
        end

        assign w_rem[j+1]  = r_rem[j];
        assign w_quot[j+1] = r_quot[j];
        assign w_den[j+1]  = r_den[j];
        assign w_ovf[j+1]  = r_ovf[j];
        assign w_vld[j+1]  = r_vld[j];
        assign w_side[j+1] = r_side[j];
    end

    assign o_valid = w_vld[QUOT_W];
    assign o_side  = w_side[QUOT_W];
    assign o_quot  = w_quot[QUOT_W];
    assign o_ovf   = w_ovf[QUOT_W];

endmodule

### design/quaternion_slerp_top.sv
// Top level of the fixed-point quaternion slerp pipeline.
//
// Input channel i_in carries start quaternion a, end quaternion b (signed Q2.14)
// and fraction frac (Q1.14); output channel o_out carries the blended quaternion
// (saturated Q2.14) and used_lerp. Both use valid/ready; a beat moves when both
// are high. i_cfg_we/i_cfg_wdata write the lerp threshold (Q1.14); write it only
// while no beats are in flight.
// Throughput: one beat per cycle while o_out.ready stays high. Beats pass through the
// 31-stage square root, the two CORDIC pipelines and the 33-stage ratio divider.
// All stages advance together. The output register plus one skid register sit
// behind the pipeline, so the pipeline keeps moving while one result waits; once
// the skid register fills, i_in.ready drops and every stage holds its beat until
// o_out.ready returns. Nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits, including the skid and output valid
// flags, and loads the threshold with 16376; the block takes beats on the next cycle.
module quaternion_slerp_top import qslerp_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [14:0]  i_cfg_wdata,
    qslerp_in_if.sink    i_in,
    qslerp_out_if.source o_out
);

    localparam int DSB_W = $bits(t_dside);
    localparam int RSB_W = $bits(t_rside);

    logic        w_en;
    logic [14:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RST;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // ---------------- stage A: lane products
    logic [3:0][15:0]        w_in_a;
    logic [3:0][15:0]        w_in_b;
    logic signed [31:0]      w_prod [4];
    logic                    r_a_vld;
    logic [3:0][15:0]        r_a_a;
    logic [3:0][15:0]        r_a_b;
    logic [14:0]             r_a_t;
    logic signed [31:0]      r_a_prod [4];

    assign w_in_a = {i_in.a_z, i_in.a_y, i_in.a_x, i_in.a_w};
    assign w_in_b = {i_in.b_z, i_in.b_y, i_in.b_x, i_in.b_w};

    for (genvar gi = 0; gi < 4; gi++) begin : g_prod
        assign w_prod[gi] = $signed(w_in_a[gi]) * $signed(w_in_b[gi]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_a <= w_in_a;
            r_a_b <= w_in_b;
            r_a_t <= i_in.frac;
            for (int i = 0; i < 4; i++) begin
                r_a_prod[i] <= w_prod[i];
            end
        end
    end

    // ---------------- stage B: dot sum, short-arc flip
    logic signed [33:0] w_dot;
    logic signed [33:0] w_dneg;
    logic               w_neg;
    logic [3:0][16:0]   w_e;
    logic               r_b_vld;
    logic [32:0]        r_b_dot;
    logic [3:0][15:0]   r_b_a;
    logic [3:0][16:0]   r_b_e;
    logic [14:0]        r_b_t;

    assign w_dot  = r_a_prod[0] + r_a_prod[1] + r_a_prod[2] + r_a_prod[3];
    assign w_dneg = -w_dot;
    assign w_neg  = w_dot[33];

    for (genvar gi = 0; gi < 4; gi++) begin : g_flip
        logic [16:0] w_bx;
        logic [16:0] w_bn;
        assign w_bx     = {r_a_b[gi][15], r_a_b[gi]};
        assign w_bn     = -w_bx;
        assign w_e[gi]  = w_neg ? w_bn : w_bx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_dot <= w_neg ? w_dneg[32:0] : w_dot[32:0];
            r_b_a   <= r_a_a;
            r_b_e   <= w_e;
            r_b_t   <= r_a_t;
        end
    end

    // ---------------- stage C: threshold test and clamp
    logic [32:0] w_thr;
    logic        w_big;
    logic [28:0] w_d;
    logic        r_c_vld;
    t_side       r_c_side;
    logic [28:0] r_c_d;

    assign w_thr = {4'b0, r_thr, 14'b0};
    assign w_big = r_b_dot >= DOT_ONE;
    assign w_d   = w_big ? DOT_ONE[28:0] : r_b_dot[28:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_side.a    <= r_b_a;
            r_c_side.e    <= r_b_e;
            r_c_side.frac <= r_b_t;
            // a clamped dot of one gives sin(theta0) = 0, which also takes the lerp path
            r_c_side.lerp <= (r_b_dot > w_thr) || w_big;
            r_c_side.d30  <= {w_d, 2'b00};
            r_c_side.s30  <= '0;
            r_c_d         <= w_d;
        end
    end

    // ---------------- stage D: d squared
    logic        r_d_vld;
    t_side       r_d_side;
    logic [57:0] r_d_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_side <= r_c_side;
            r_d_sq   <= r_c_d * r_c_d;
        end
    end

    // ---------------- stage E: radicand 1 - d30^2 in Q.60
    logic [61:0]      w_sq16;
    logic             r_e_vld;
    t_side            r_e_side;
    logic [RAD_W-1:0] r_e_rad;

    assign w_sq16 = {r_d_sq, 4'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_side <= r_d_side;
            r_e_rad  <= RAD_ONE - w_sq16[RAD_W-1:0];
        end
    end

    // ---------------- square root: sin(theta0)
    logic              w_sq_vld;
    logic [SIDE_W-1:0] w_sq_sb;
    logic [ROOT_W-1:0] w_root;
    t_side             w_sq_side;

    qslerp_sqrt #(
        .SB_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_vld),
        .i_side  (r_e_side),
        .i_rad   (r_e_rad),
        .o_valid (w_sq_vld),
        .o_side  (w_sq_sb),
        .o_root  (w_root)
    );

    always_comb begin
        w_sq_side     = w_sq_sb;
        w_sq_side.s30 = w_root;
    end

    // ---------------- vectoring CORDIC: theta0 = atan2(s30, d30)
    logic                    w_v_vld;
    logic [SIDE_W-1:0]       w_v_sb;
    logic signed [ANG_W-1:0] w_theta0;

    qslerp_cordic #(
        .NSTAGE (CORDIC_STAGES),
        .VECTOR (1'b1),
        .SB_W   (SIDE_W)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_vld),
        .i_side  (w_sq_side),
        .i_x     ($signed({3'b0, w_sq_side.d30})),
        .i_y     ($signed({3'b0, w_root})),
        .i_z     ('0),
        .o_valid (w_v_vld),
        .o_side  (w_v_sb),
        .o_x     (),
        .o_y     (),
        .o_z     (w_theta0)
    );

    // ---------------- stage F: theta0 * t
    t_side              w_v_side;
    logic signed [49:0] w_p;
    logic               r_f_vld;
    t_side              r_f_side;
    logic signed [49:0] r_f_p;

    assign w_v_side = w_v_sb;
    assign w_p      = w_theta0 * $signed({1'b0, w_v_side.frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= w_v_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_side <= w_v_side;
            r_f_p    <= w_p;
        end
    end

    // ---------------- stage G: round theta, fold above pi/2
    logic signed [49:0]      w_th;
    logic signed [49:0]      w_phi;
    logic                    w_swap;
    logic                    r_g_vld;
    t_rside                  r_g_rs;
    logic signed [ANG_W-1:0] r_g_phi;

    assign w_th   = (r_f_p + 50'sd8192) >>> 14;
    assign w_swap = w_th > HALF_PI_P;
    assign w_phi  = w_swap ? w_th - HALF_PI_P : w_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_rs.side <= r_f_side;
            r_g_rs.swap <= w_swap;
            r_g_phi     <= w_phi[ANG_W-1:0];
        end
    end

    // ---------------- rotation CORDIC: cos/sin of theta
    logic                    w_r_vld;
    logic [RSB_W-1:0]        w_r_sb;
    t_rside                  w_r_rs;
    logic signed [ANG_W-1:0] w_cx;
    logic signed [ANG_W-1:0] w_sy;

    qslerp_cordic #(
        .NSTAGE (CORDIC_STAGES),
        .VECTOR (1'b0),
        .SB_W   (RSB_W)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_vld),
        .i_side  (r_g_rs),
        .i_x     (KINV30),
        .i_y     ('0),
        .i_z     (r_g_phi),
        .o_valid (w_r_vld),
        .o_side  (w_r_sb),
        .o_x     (w_cx),
        .o_y     (w_sy),
        .o_z     ()
    );

    assign w_r_rs = w_r_sb;

    // ---------------- stage H: undo the fold, sign/magnitude of sin
    logic signed [ANG_W-1:0] w_ct;
    logic signed [ANG_W-1:0] w_st;
    logic signed [ANG_W-1:0] w_stn;
    logic                    r_h_vld;
    t_dside                  r_h_ds;
    logic [QUOT_W-1:0]       r_h_mag;

    assign w_ct  = w_r_rs.swap ? -w_sy : w_cx;
    assign w_st  = w_r_rs.swap ? w_cx : w_sy;
    assign w_stn = -w_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_h_vld <= w_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_ds.side <= w_r_rs.side;
            r_h_ds.ct   <= w_ct;
            r_h_ds.neg  <= w_st[ANG_W-1];
            r_h_mag     <= w_st[ANG_W-1] ? w_stn[QUOT_W-1:0] : w_st[QUOT_W-1:0];
        end
    end

    // ---------------- divider: s1 = sin(theta) / sin(theta0)
    logic              w_q_vld;
    logic [DSB_W-1:0]  w_q_sb;
    t_dside            w_q_ds;
    logic [QUOT_W-1:0] w_quot;
    logic              w_ovf;

    qslerp_div #(
        .SB_W (DSB_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_h_vld),
        .i_side  (r_h_ds),
        .i_num   (r_h_mag),
        .i_den   (r_h_ds.side.s30),
        .o_valid (w_q_vld),
        .o_side  (w_q_sb),
        .o_quot  (w_quot),
        .o_ovf   (w_ovf)
    );

    assign w_q_ds = w_q_sb;

    // ---------------- stage I: saturate and sign the ratio
    logic [QUOT_W-1:0]       w_mag;
    logic [ANG_W-1:0]        w_qpos;
    logic                    r_i_vld;
    t_side                   r_i_side;
    logic signed [ANG_W-1:0] r_i_ct;
    logic signed [ANG_W-1:0] r_i_q;

    assign w_mag  = (w_ovf || (w_quot > QMAX)) ? QMAX : w_quot;
    assign w_qpos = {1'b0, w_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else if (w_en) begin
            r_i_vld <= w_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_side <= w_q_ds.side;
            r_i_ct   <= w_q_ds.ct;
            r_i_q    <= w_q_ds.neg ? -$signed(w_qpos) : $signed(w_qpos);
        end
    end

    // ---------------- stage J: d30 * s1
    logic signed [65:0]      w_dq;
    logic                    r_j_vld;
    t_side                   r_j_side;
    logic signed [ANG_W-1:0] r_j_ct;
    logic signed [ANG_W-1:0] r_j_q;
    logic signed [65:0]      r_j_dq;

    assign w_dq = $signed({1'b0, r_i_side.d30}) * r_i_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else if (w_en) begin
            r_j_vld <= r_i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_side <= r_i_side;
            r_j_ct   <= r_i_ct;
            r_j_q    <= r_i_q;
            r_j_dq   <= w_dq;
        end
    end

    // ---------------- stage K: s0 = cos(theta) - round(d * s1)
    logic signed [65:0]      w_rdq;
    logic signed [65:0]      w_s0;
    logic                    r_k_vld;
    t_side                   r_k_side;
    logic signed [ANG_W-1:0] r_k_q;
    logic signed [36:0]      r_k_s0;

    assign w_rdq = (r_j_dq + 66'sd536870912) >>> 30;
    assign w_s0  = r_j_ct - w_rdq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else if (w_en) begin
            r_k_vld <= r_j_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_side <= r_j_side;
            r_k_q    <= r_j_q;
            r_k_s0   <= w_s0[36:0];
        end
    end

    // ---------------- stage L: lane weights times a and e, lerp step
    logic signed [52:0] w_pa [4];
    logic signed [50:0] w_pe [4];
    logic signed [33:0] w_lp [4];
    logic               r_l_vld;
    t_side              r_l_side;
    logic signed [52:0] r_l_pa [4];
    logic signed [50:0] r_l_pe [4];
    logic signed [33:0] r_l_lp [4];

    for (genvar gi = 0; gi < 4; gi++) begin : g_blend
        logic signed [15:0] w_av;
        logic signed [16:0] w_ev;
        logic signed [17:0] w_ea;
        assign w_av     = r_k_side.a[gi];
        assign w_ev     = r_k_side.e[gi];
        assign w_ea     = w_ev - w_av;
        assign w_pa[gi] = r_k_s0 * w_av;
        assign w_pe[gi] = r_k_q * w_ev;
        assign w_lp[gi] = $signed({1'b0, r_k_side.frac}) * w_ea;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end else if (w_en) begin
            r_l_vld <= r_k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_side <= r_k_side;
            for (int i = 0; i < 4; i++) begin
                r_l_pa[i] <= w_pa[i];
                r_l_pe[i] <= w_pe[i];
                r_l_lp[i] <= w_lp[i];
            end
        end
    end

    // ---------------- final sum, rounding, saturation
    t_res w_res;

    for (genvar gi = 0; gi < 4; gi++) begin : g_final
        logic signed [53:0] w_sum;
        logic signed [53:0] w_rs;
        logic signed [53:0] w_lr;
        assign w_sum = r_l_pa[gi] + r_l_pe[gi];
        assign w_rs  = (w_sum + 54'sd536870912) >>> 30;
        assign w_lr  = $signed(r_l_side.a[gi]) + ((r_l_lp[gi] + 34'sd8192) >>> 14);
        assign w_res.r[gi] = sat16(r_l_side.lerp ? w_lr : w_rs);
    end

    assign w_res.lerp = r_l_side.lerp;

    // ---------------- output register and skid
    logic r_out_vld;
    t_res r_out;
    logic r_skid_vld;
    t_res r_skid;

    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_out_vld && o_out.ready) begin
                r_out_vld  <= r_skid_vld;
                r_skid_vld <= 1'b0;
            end
            if (w_en && r_l_vld) begin
                if (!r_out_vld || o_out.ready) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && o_out.ready && r_skid_vld) begin
            r_out <= r_skid;
        end
        if (w_en && r_l_vld) begin
            if (!r_out_vld || o_out.ready) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.r_w       = r_out.r[0];
    assign o_out.r_x       = r_out.r[1];
    assign o_out.r_y       = r_out.r[2];
    assign o_out.r_z       = r_out.r[3];
    assign o_out.used_lerp = r_out.lerp;

    // ---------------- checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a beat while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !o_out.ready))
        else $error("skid register filled without an output stall");

    a_slerp_has_sine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && !r_c_side.lerp) |-> (r_c_d < DOT_ONE[28:0]))
        else $error("slerp path entered with a dot of one");

endmodule

### sim/tb_top.sv
// Self-checking testbench for quaternion_slerp_top: random and directed beats against a predictor.
module tb_top import qslerp_pkg::*; ();

    localparam int LATENCY = 77 + 2 * 16;
    localparam int CFG_THR = 0;

    typedef logic [15:0] quat_t [4];

    typedef struct {
        logic [15:0] r [4];
        logic        lerp;
    } blend_t;

    class slerp_scoreboard;
        logic [14:0] thresh;
        blend_t      pending_q [$];
        int          n_bad;
        longint      atan_q30 [16] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

        function new();
            thresh = THRESH_RST;
            n_bad  = 0;
        endfunction

        function longint rnd(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function logic [15:0] clip16(longint v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function longint root(longint unsigned n);
            longint unsigned res, bm;
            res = 0;
            bm  = 64'd1 << 62;
            while (bm > n) bm = bm >> 2;
            while (bm != 0) begin
                if (n >= res + bm) begin
                    n   = n - (res + bm);
                    res = (res >> 1) + bm;
                end else begin
                    res = res >> 1;
                end
                bm = bm >> 2;
            end
            return longint'(res);
        endfunction

        function longint vec_angle(longint x, longint y);
            longint z, xs, ys;
            z = 0;
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z += atan_q30[i];
                end else begin
                    x = x - ys; y = y + xs; z -= atan_q30[i];
                end
            end
            return z;
        endfunction

        task rotate(input longint phi, output longint c, output longint s);
            longint x, y, z, xs, ys;
            x = 64'h26DD3B6A; y = 0; z = phi;
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z -= atan_q30[i];
                end else begin
                    x = x + ys; y = y - xs; z += atan_q30[i];
                end
            end
            c = x;
            s = y;
        endtask

        task note(input quat_t qa, input quat_t qb, input logic [14:0] tf);
            longint a [4], e [4], r [4];
            longint t, dot, d, d30, s30, theta0, theta, ct, st, c, s, q, s0;
            longint one30, hp30;
            bit lerp;
            blend_t o;
            one30 = 64'sd1 <<< 30;
            hp30  = 64'h6487ED51;
            t = tf;
            dot = 0; d30 = 0; s30 = 0;
            for (int i = 0; i < 4; i++) begin
                a[i] = longint'($signed(qa[i]));
                e[i] = longint'($signed(qb[i]));
                dot += a[i] * e[i];
            end
            if (dot < 0) begin
                dot = -dot;
                for (int i = 0; i < 4; i++) e[i] = -e[i];
            end
            lerp = dot > (longint'(thresh) <<< 14);
            if (!lerp) begin
                d   = (dot > (64'sd1 <<< 28)) ? (64'sd1 <<< 28) : dot;
                d30 = d * 4;
                s30 = root((64'd1 << 60) - longint'(d30 * d30));
                if (s30 == 0) lerp = 1;
            end
            if (lerp) begin
                for (int i = 0; i < 4; i++) r[i] = a[i] + rnd(t * (e[i] - a[i]), 14);
            end else begin
                theta0 = vec_angle(d30, s30);
                theta  = rnd(theta0 * t, 14);
                // past a quarter turn: fold back and swap cos/sin
                if (theta > hp30) begin
                    rotate(theta - hp30, c, s);
                    ct = -s;
                    st = c;
                end else begin
                    rotate(theta, ct, st);
                end
                q = (st * one30) / s30;
                if (q > 4 * one30) q = 4 * one30;
                if (q < -4 * one30) q = -4 * one30;
                s0 = ct - rnd(d30 * q, 30);
                for (int i = 0; i < 4; i++) r[i] = rnd(s0 * a[i] + q * e[i], 30);
            end
            for (int i = 0; i < 4; i++) o.r[i] = clip16(r[i]);
            o.lerp = lerp;
            pending_q.push_back(o);
        endtask

        function void check(blend_t got);
            blend_t w;
            bit bad;
            if (pending_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result beat at %0t", $realtime);
                return;
            end
            w = pending_q.pop_front();
            bad = (got.lerp !== w.lerp);
            for (int i = 0; i < 4; i++) if (got.r[i] !== w.r[i]) bad = 1;
            if (bad) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: exp %h %h %h %h lerp %b, got %h %h %h %h lerp %b",
                             w.r[0], w.r[1], w.r[2], w.r[3], w.lerp,
                             got.r[0], got.r[1], got.r[2], got.r[3], got.lerp);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [14:0] cfg_wdata;
    bit          calm;

    qslerp_in_if  in_ch ();
    qslerp_out_if out_ch ();

    slerp_scoreboard sb = new();

    quaternion_slerp_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // result beats: sampled mid-cycle, when all outputs and our ready are settled
    always @(negedge i_clk) begin
        blend_t got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.r[0] = out_ch.r_w;
            got.r[1] = out_ch.r_x;
            got.r[2] = out_ch.r_y;
            got.r[3] = out_ch.r_z;
            got.lerp = out_ch.used_lerp;
            sb.check(got);
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!calm) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    end

    task send_beat(input quat_t qa, input quat_t qb, input logic [14:0] tf);
        bit taken;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.a_w <= qa[0]; in_ch.a_x <= qa[1]; in_ch.a_y <= qa[2]; in_ch.a_z <= qa[3];
        in_ch.b_w <= qb[0]; in_ch.b_x <= qb[1]; in_ch.b_y <= qb[2]; in_ch.b_z <= qb[3];
        in_ch.frac <= tf;
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        sb.note(qa, qb, tf);
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 40) @(posedge i_clk);
    endtask

    task write_thresh(input logic [14:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.thresh = v;
    endtask

    function logic [15:0] rnd_comp(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task make_pair(output quat_t qa, output quat_t qb, output logic [14:0] tf);
        int mode;
        bit flip;
        mode = $urandom_range(0, 9);
        flip = $urandom_range(0, 1);
        for (int i = 0; i < 4; i++) begin
            case (mode)
                0, 1: begin
                    qa[i] = 16'($urandom);
                    qb[i] = 16'($urandom);
                end
                2, 3, 4, 5: begin
                    qa[i] = rnd_comp(9000);
                    qb[i] = rnd_comp(9000);
                end
                6, 7, 8: begin
                    qa[i] = rnd_comp(8000);
                    qb[i] = qa[i] + rnd_comp(300);
                end
                default: begin
                    qa[i] = rnd_comp(8192);
                    qb[i] = qa[i];
                end
            endcase
            if (mode >= 6 && flip) qb[i] = -qb[i];
        end
        tf = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
    endtask

    task directed();
        quat_t qa, qb;
        logic [14:0] fr [5];
        fr = '{15'd0, 15'd8192, 15'd16384, 15'd32767, 15'd4096};
        qa = '{16'd16384, 16'd0, 16'd0, 16'd0};
        foreach (fr[k]) begin
            send_beat(qa, '{16'd0, 16'd16384, 16'd0, 16'd0}, fr[k]);   // orthogonal
        end
        send_beat(qa, qa, 15'd8192);                                     // identical
        send_beat(qa, '{16'hC000, 16'd0, 16'd0, 16'd0}, 15'd8192);      // opposite
        send_beat(qa, '{16'd11585, 16'd11585, 16'd0, 16'd0}, 15'd16384);
        send_beat(qa, '{16'hD2BF, 16'd11585, 16'd0, 16'd0}, 15'd12000); // obtuse
        send_beat('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
                  '{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 15'd16384);
        send_beat('{16'h8000, 16'h8000, 16'h8000, 16'h8000},
                  '{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 15'd32767);
        send_beat('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                  '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 15'h7FFF);
        send_beat('{16'd0, 16'd0, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0, 16'd0}, 15'd8192);
        send_beat('{16'd0, 16'd0, 16'd0, 16'd0}, qa, 15'd16384);
        send_beat('{16'd16384, 16'd16384, 16'd0, 16'd0}, '{16'd16384, 16'd0, 16'd0, 16'd0},
                  15'd8192);   // dot of exactly one
        send_beat('{16'd8192, 16'd8192, 16'd8192, 16'd8192},
                  '{16'd8192, 16'd8192, 16'd8192, 16'd8000}, 15'd10000);
    endtask

    initial begin
        logic [14:0] thr_list [6];
        quat_t qa, qb;
        logic [14:0] tf;
        thr_list = '{THRESH_RST, 15'd16384, 15'd0, 15'h7FFF, 15'($urandom), 15'd12000};
        calm = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.a_w = '0; in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
        in_ch.b_w = '0; in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
        in_ch.frac = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (thr_list[p]) begin
            if (p != CFG_THR) write_thresh(thr_list[p]);
            if (p <= 1) directed();
            for (int n = 0; n < 270; n++) begin
                if (p == 5 && n > 70) calm = 1;
                make_pair(qa, qb, tf);
                send_beat(qa, qb, tf);
            end
            drain();
        end
        if (sb.n_bad == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
